/* rtl/gbr_pkg.sv */
// Shared types, constants and the per-channel kernel for the 3x3 RGB blur.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gbr_pkg;

    localparam int ROW_W      = 16;
    localparam int COL_W      = 10;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int FW_W       = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = FIFO_AW + 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd500;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 16'd500;

    // result slots of one pixel word
    localparam int EMIT_CENTRE = 0;
    localparam int EMIT_RIGHT  = 1;
    localparam int EMIT_BOTTOM = 2;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        pixel_t           px;
        pixel_t           mid;
        pixel_t           val0;
        logic [2:0]       emit;
    } work_t;

    function automatic logic [CH_W-1:0] blur_chan(
        input logic [CH_W-1:0] t0, input logic [CH_W-1:0] m0, input logic [CH_W-1:0] b0,
        input logic [CH_W-1:0] t1, input logic [CH_W-1:0] m1, input logic [CH_W-1:0] b1,
        input logic [CH_W-1:0] t2, input logic [CH_W-1:0] m2, input logic [CH_W-1:0] b2);
        logic [11:0] s;
        s = 12'(t0) + (12'(t1) << 1) + 12'(t2)
          + (12'(m0) << 1) + (12'(m1) << 2) + (12'(m2) << 1)
          + 12'(b0) + (12'(b1) << 1) + 12'(b2) + 12'd8;
        return s[11:4];
    endfunction

endpackage

/* rtl/gaussian_blur_3x3_rgb.sv */
// 3x3 Gaussian blur on a raster-order 24-bit RGB stream, top level.
// Depends on gbr_pkg, gbr_front, gbr_fifo and gbr_back.
//
// Usage:
//   Pixels enter on in_valid / in_stall, one word per accepted edge, in raster
//   order for frames of frame_width x frame_height (cfg port, index 0 and 1,
//   written while the block is idle). Each pixel (r,c) releases pixel
//   (r-1,c-1) with its coordinates; last-column and last-row pixels follow
//   at once, so one input gives zero to three output words. run_last marks
//   the final word of one input. Interior pixels get the 1-2-1 kernel per
//   channel with rounding; border pixels pass unchanged.
//   The first result of a pixel passes the stage register, the work queue
//   and the output register. Throughput: one pixel per clock while each pixel
//   gives one result and out_stall is low; the output register emits one word
//   per clock while not stalled, so border pixels with extra results slow input.
//   Reset clears counters and queue and sets both sizes to 500; line stores
//   hold no reset value. When the receiver stalls, the output word holds and
//   the four-entry queue fills; in_stall rises once queue plus stage hold four.
`timescale 1ns / 1ps

module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [gbr_pkg::CH_W-1:0]       in_blue,
    input  logic [gbr_pkg::CH_W-1:0]       in_green,
    input  logic [gbr_pkg::CH_W-1:0]       in_red,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [gbr_pkg::ROW_W-1:0]      out_row,
    output logic [gbr_pkg::COL_W-1:0]      out_col,
    output logic [gbr_pkg::CH_W-1:0]       out_blue,
    output logic [gbr_pkg::CH_W-1:0]       out_green,
    output logic [gbr_pkg::CH_W-1:0]       out_red,
    output logic                           run_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gbr_pkg::*;

    logic             push;
    work_t            push_data;
    logic             pop;
    work_t            head;
    logic             head_valid;
    logic [LVL_W-1:0] fifo_level;

    gbr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_blue    (in_blue),
        .in_green   (in_green),
        .in_red     (in_red),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fifo_level (fifo_level),
        .push       (push),
        .push_data  (push_data)
    );

    gbr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .level      (fifo_level)
    );

    gbr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .run_last   (run_last)
    );

endmodule

/* rtl/gbr_front.sv */
// Front end: accepts pixels, keeps frame counters, line stores and the window,
// computes the kernel and pushes one work record per pixel. Uses gbr_pkg.
`timescale 1ns / 1ps

module gbr_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [gbr_pkg::CH_W-1:0]       in_blue,
    input  logic [gbr_pkg::CH_W-1:0]       in_green,
    input  logic [gbr_pkg::CH_W-1:0]       in_red,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [gbr_pkg::LVL_W-1:0]      fifo_level,
    output logic                           push,
    output gbr_pkg::work_t                 push_data
);
    import gbr_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

    logic [FW_W-1:0]  width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;

    logic             s1_valid_reg;
    pixel_t           s1_px_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [AW-1:0]    s1_idx_reg;
    logic [2:0]       s1_emit_reg;
    logic             s1_inner_reg;
    pixel_t           top_q_reg;
    pixel_t           mid_q_reg;
    pixel_t           win_reg [6];

    pixel_t           older_line [MAX_WIDTH];
    pixel_t           newer_line [MAX_WIDTH];

    logic             accept;
    pixel_t           px;
    logic [AW-1:0]    idx;
    logic [WW-1:0]    fw_ext;
    logic [WW-1:0]    w_eff;
    logic [WW-1:0]    w_last;
    logic [WW-1:0]    c_ext;
    logic [ROW_W-1:0] h_last;
    logic             last_col;
    logic             last_row;
    logic             inner;
    logic [2:0]       emit;
    pixel_t           blur_px;
    logic [LVL_W-1:0] fill;

    assign cfg_ready = 1'b1;
    assign fill      = fifo_level + LVL_W'(s1_valid_reg);
    assign in_stall  = (fill >= LVL_W'(FIFO_DEPTH));
    assign accept    = in_valid && !in_stall;
    assign px        = {in_red, in_green, in_blue};
    assign idx       = AW'(col_reg);

    always_comb
    begin
        fw_ext = WW'(width_reg);
        if (fw_ext < WW'(3))
            w_eff = WW'(3);
        else if (fw_ext > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = fw_ext;
        w_last   = w_eff - WW'(1);
        c_ext    = WW'(col_reg);
        h_last   = ((height_reg < ROW_W'(3)) ? ROW_W'(3) : height_reg) - ROW_W'(1);
        last_col = (c_ext >= w_last);
        last_row = (row_reg >= h_last);
        inner    = (row_reg >= ROW_W'(2)) && (row_reg <= h_last)
                && (col_reg >= COL_W'(2)) && (c_ext <= w_last);
        emit              = '0;
        emit[EMIT_CENTRE] = (row_reg != '0) && (col_reg != '0);
        emit[EMIT_RIGHT]  = (row_reg != '0) && last_col;
        emit[EMIT_BOTTOM] = last_row;
    end

    // configuration and frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= FRAME_WIDTH_RST;
            height_reg   <= FRAME_HEIGHT_RST;
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg <= cfg_data[FW_W-1:0];
                else if (cfg_index == REG_FRAME_HEIGHT)
                    height_reg <= cfg_data[ROW_W-1:0];
            end
            if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // stage payload and line stores
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= px;
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_idx_reg   <= idx;
            s1_emit_reg  <= emit;
            s1_inner_reg <= inner;
            top_q_reg    <= older_line[idx];
            mid_q_reg    <= newer_line[idx];
        end
        if (s1_valid_reg)
        begin
            older_line[s1_idx_reg] <= mid_q_reg;
            newer_line[s1_idx_reg] <= s1_px_reg;
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_q_reg;
            win_reg[4] <= mid_q_reg;
            win_reg[5] <= s1_px_reg;
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            blur_px[ch*CH_W +: CH_W] = blur_chan(
                win_reg[0][ch*CH_W +: CH_W], win_reg[1][ch*CH_W +: CH_W],
                win_reg[2][ch*CH_W +: CH_W], win_reg[3][ch*CH_W +: CH_W],
                win_reg[4][ch*CH_W +: CH_W], win_reg[5][ch*CH_W +: CH_W],
                top_q_reg[ch*CH_W +: CH_W], mid_q_reg[ch*CH_W +: CH_W],
                s1_px_reg[ch*CH_W +: CH_W]);
        end
    end

    assign push           = s1_valid_reg;
    assign push_data.row  = s1_row_reg;
    assign push_data.col  = s1_col_reg;
    assign push_data.px   = s1_px_reg;
    assign push_data.mid  = mid_q_reg;
    assign push_data.val0 = s1_inner_reg ? blur_px : win_reg[4];
    assign push_data.emit = s1_emit_reg;

endmodule

/* rtl/gbr_fifo.sv */
// Short work queue between the front end and the result sequencer.
// Uses gbr_pkg for the record type and depth.
`timescale 1ns / 1ps

module gbr_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  gbr_pkg::work_t            push_data,
    input  logic                      pop,
    output gbr_pkg::work_t            head,
    output logic                      head_valid,
    output logic [gbr_pkg::LVL_W-1:0] level
);
    import gbr_pkg::*;

    work_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [LVL_W-1:0]   count_reg;
    logic               do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign level      = count_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            if (push && !do_pop)
                count_reg <= count_reg + LVL_W'(1);
            else if (do_pop && !push)
                count_reg <= count_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/gbr_back.sv */
// Result sequencer: expands each work record into its zero to three results
// and holds them in the output register. Uses gbr_pkg.
`timescale 1ns / 1ps

module gbr_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gbr_pkg::work_t            head,
    input  logic                      head_valid,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [gbr_pkg::ROW_W-1:0] out_row,
    output logic [gbr_pkg::COL_W-1:0] out_col,
    output logic [gbr_pkg::CH_W-1:0]  out_blue,
    output logic [gbr_pkg::CH_W-1:0]  out_green,
    output logic [gbr_pkg::CH_W-1:0]  out_red,
    output logic                      run_last
);
    import gbr_pkg::*;

    logic             out_valid_reg;
    logic [2:0]       done_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    pixel_t           pix_reg;
    logic             last_reg;

    logic [2:0]       pending;
    logic [2:0]       pick;
    logic             is_last;
    logic             take;
    logic             emit_now;
    logic [ROW_W-1:0] row_sel;
    logic [COL_W-1:0] col_sel;
    pixel_t           pix_sel;

    always_comb
    begin
        pending = head.emit & ~done_reg;
        pick    = '0;
        if (pending[EMIT_CENTRE])
            pick[EMIT_CENTRE] = 1'b1;
        else if (pending[EMIT_RIGHT])
            pick[EMIT_RIGHT] = 1'b1;
        else if (pending[EMIT_BOTTOM])
            pick[EMIT_BOTTOM] = 1'b1;
        is_last  = ((pending & ~pick) == '0);
        take     = head_valid && (!out_valid_reg || !out_stall);
        emit_now = take && (pending != '0);
        pop      = take && ((pending == '0) || is_last);

        if (pick[EMIT_CENTRE])
        begin
            row_sel = head.row - ROW_W'(1);
            col_sel = head.col - COL_W'(1);
            pix_sel = head.val0;
        end
        else if (pick[EMIT_RIGHT])
        begin
            row_sel = head.row - ROW_W'(1);
            col_sel = head.col;
            pix_sel = head.mid;
        end
        else
        begin
            row_sel = head.row;
            col_sel = head.col;
            pix_sel = head.px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            if (emit_now)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (pop)
                done_reg <= '0;
            else if (emit_now)
                done_reg <= done_reg | pick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            row_reg  <= row_sel;
            col_reg  <= col_sel;
            pix_reg  <= pix_sel;
            last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_blue  = pix_reg[CH_W-1:0];
    assign out_green = pix_reg[2*CH_W-1:CH_W];
    assign out_red   = pix_reg[3*CH_W-1:2*CH_W];
    assign run_last  = last_reg;

endmodule

/* bench/tb_gaussian_blur_3x3_rgb.sv */
// Self-checking bench for gaussian_blur_3x3_rgb: a scripted opening, random frames
// of varied size, then a calm final frame, each output word checked against a local blur.
// Depends on gbr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_gaussian_blur_3x3_rgb;
    import gbr_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int DRAIN_CYCLES = 8;
    localparam int SQUEEZE_LEN  = 90;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int unsigned KERNEL [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

    typedef enum logic {STEP_CFG, STEP_PIXEL} step_e;

    typedef struct packed {
        step_e                 kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        pixel_t                px;
        logic                  typed;
        pixel_t                want;
    } script_row_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        pixel_t           px;
        logic             last;
    } blur_word_t;

    localparam script_row_t SCRIPT [25] = '{
        '{STEP_CFG,   REG_FRAME_WIDTH,  16'd3,    24'h000000, 1'b0, 24'h000000},
        '{STEP_CFG,   REG_FRAME_HEIGHT, 16'd3,    24'h000000, 1'b0, 24'h000000},
        '{STEP_CFG,   REG_SPARE,        16'hFFFF, 24'h000000, 1'b0, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{STEP_CFG,   REG_FRAME_WIDTH,  16'd4,    24'h000000, 1'b0, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'h000000, 1'b0, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFF00FF, 1'b0, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'h00FF00, 1'b0, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'h123456, 1'b0, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'h000000, 1'b0, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'h80FF7F, 1'b0, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'h7F0080, 1'b0, 24'h000000},
        // narrow the frame mid-row: the next column already lies past the last
        '{STEP_CFG,   REG_FRAME_WIDTH,  16'd3,    24'h000000, 1'b0, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hA5C3E1, 1'b0, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'h000000, 1'b1, 24'h000000},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,    24'h5A3C1E, 1'b0, 24'h000000}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [CH_W-1:0]       in_blue;
    logic [CH_W-1:0]       in_green;
    logic [CH_W-1:0]       in_red;
    logic                  out_valid;
    logic                  out_stall;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic [CH_W-1:0]       out_blue;
    logic [CH_W-1:0]       out_green;
    logic [CH_W-1:0]       out_red;
    logic                  run_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pixel_t           store_far [MAX_W];
    pixel_t           store_near [MAX_W];
    pixel_t           win [6];
    logic [ROW_W-1:0] row_at;
    logic [COL_W-1:0] col_at;
    logic [FW_W-1:0]  width_set;
    logic [ROW_W-1:0] height_set;
    blur_word_t       owed [$];
    int               mismatches;
    bit               calm;
    bit               squeeze_req;

    gaussian_blur_3x3_rgb dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_blue   (in_blue),
        .in_green  (in_green),
        .in_red    (in_red),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .run_last  (run_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int unsigned eff_width(input logic [FW_W-1:0] w);
        return (w < 3) ? 3 : (w > MAX_W) ? MAX_W : int'(w);
    endfunction

    function automatic int unsigned eff_height(input logic [ROW_W-1:0] h);
        return (h < 3) ? 3 : int'(h);
    endfunction

    function automatic pixel_t smooth(input pixel_t [8:0] nine);
        pixel_t      res;
        int unsigned acc;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 8;
            for (int k = 0; k < 9; k++)
                acc += KERNEL[k] * int'(nine[k][ch*CH_W +: CH_W]);
            res[ch*CH_W +: CH_W] = acc[11:4];
        end
        return res;
    endfunction

    task automatic blur_pixel_step(input pixel_t px, input logic typed, input pixel_t want);
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        int unsigned  c;
        int           n;
        logic         lc;
        logic         lr;
        pixel_t       top;
        pixel_t       mid;
        pixel_t       v;
        pixel_t [8:0] nine;
        blur_word_t   got [3];
        w   = eff_width(width_set);
        h   = eff_height(height_set);
        r   = row_at;
        c   = col_at;
        lc  = c >= w - 1;
        lr  = r >= h - 1;
        top = store_far[c];
        mid = store_near[c];
        n   = 0;
        if (r >= 1 && c >= 1)
        begin
            if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w)
            begin
                for (int k = 0; k < 6; k++)
                    nine[k] = win[k];
                nine[6] = top;
                nine[7] = mid;
                nine[8] = px;
                v = smooth(nine);
            end
            else
                v = win[4];
            got[n] = '{ROW_W'(r - 1), COL_W'(c - 1), v, 1'b0};
            n++;
        end
        if (r >= 1 && lc)
        begin
            got[n] = '{ROW_W'(r - 1), COL_W'(c), mid, 1'b0};
            n++;
        end
        if (lr)
        begin
            got[n] = '{ROW_W'(r), COL_W'(c), px, 1'b0};
            n++;
        end
        for (int k = 0; k < n; k++)
        begin
            if (typed)
                got[k].px = want;
            got[k].last = (k == n - 1);
            owed.push_back(got[k]);
        end
        store_far[c]  = mid;
        store_near[c] = px;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = px;
        if (lc)
        begin
            col_at = '0;
            row_at = lr ? '0 : ROW_W'(r + 1);
        end
        else
            col_at = COL_W'(c + 1);
    endtask

    task automatic send_pixel(input pixel_t px, input logic typed, input pixel_t want);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        {in_red, in_green, in_blue} <= px;
        do
            @(posedge clk);
        while (in_stall);
        blur_pixel_step(px, typed, want);
    endtask

    // hold the input until every owed word is out, then let the pipe settle
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_FRAME_WIDTH)
            width_set = data[FW_W-1:0];
        else if (idx == REG_FRAME_HEIGHT)
            height_set = data;
    endtask

    task automatic reconfigure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        hold_until_drained();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(12_000_000);
        $display("FAIL gaussian_blur_3x3_rgb");
        $finish;
    end

    initial
    begin : receiver
        int         burst;
        blur_word_t seen;
        blur_word_t due;
        burst = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                seen = '{out_row, out_col, {out_red, out_green, out_blue}, run_last};
                if (owed.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got row %0d col %0d rgb %h last %b",
                             $time, seen.row, seen.col, seen.px, seen.last);
                    mismatches++;
                end
                else
                begin
                    due = owed.pop_front();
                    if (seen !== due)
                    begin
                        $display("%0t: word mismatch, expected row %0d col %0d rgb %h last %b",
                                 $time, due.row, due.col, due.px, due.last);
                        $display("%0t:                got      row %0d col %0d rgb %h last %b",
                                 $time, seen.row, seen.col, seen.px, seen.last);
                        mismatches++;
                    end
                end
            end
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                burst = SQUEEZE_LEN;
            end
            else if (burst == 0 && !calm && $urandom_range(0, 9) == 0)
                burst = $urandom_range(1, 15);
            out_stall <= (burst > 0);
            if (burst > 0)
                burst--;
        end
    end

    initial
    begin : stimulus
        int unsigned           w_eff;
        int unsigned           h_eff;
        int unsigned           frames;
        int unsigned           random_fed;
        int unsigned           phase;
        logic [CFG_DATA_W-1:0] w_val;
        logic [CFG_DATA_W-1:0] h_val;
        rst_n       = 1'b0;
        in_valid    <= 1'b0;
        in_blue     <= '0;
        in_green    <= '0;
        in_red      <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_FRAME_WIDTH;
        cfg_data    <= '0;
        calm        = 1'b0;
        squeeze_req = 1'b0;
        mismatches  = 0;
        row_at      = '0;
        col_at      = '0;
        width_set   = FRAME_WIDTH_RST;
        height_set  = FRAME_HEIGHT_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(SCRIPT); i++)
        begin
            if (SCRIPT[i].kind == STEP_CFG)
            begin
                hold_until_drained();
                write_reg(SCRIPT[i].idx, SCRIPT[i].data);
                cfg_valid <= 1'b0;
            end
            else
                send_pixel(SCRIPT[i].px, SCRIPT[i].typed, SCRIPT[i].want);
        end

        // whole frames only, so every size change lands on a frame boundary
        random_fed = 0;
        phase = 0;
        while (random_fed < 130)
        begin
            if (phase == 0)
            begin
                w_val = 16'd8;
                h_val = 16'd6;
            end
            else
            begin
                w_val[CFG_DATA_W-1:FW_W] = (CFG_DATA_W - FW_W)'($urandom());
                w_val[FW_W-1:0] = ($urandom_range(0, 5) == 0) ? FW_W'($urandom_range(0, 2))
                                                              : FW_W'($urandom_range(3, 9));
                h_val = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                                    : CFG_DATA_W'($urandom_range(3, 7));
            end
            reconfigure(w_val, h_val);
            calm   = (phase != 0) && ($urandom_range(0, 3) == 0);
            w_eff  = eff_width(w_val[FW_W-1:0]);
            h_eff  = eff_height(h_val);
            frames = (phase == 0) ? 2 : $urandom_range(1, 2);
            for (int k = 0; k < frames * w_eff * h_eff; k++)
            begin
                if (phase == 0 && k == 10)
                    squeeze_req = 1'b1;
                send_pixel(pixel_t'($urandom()), 1'b0, '0);
                random_fed++;
            end
            phase++;
        end

        // one last whole frame, sent with no input idling and no new output stall bursts
        reconfigure(16'd12, 16'd4);
        calm = 1'b1;
        for (int k = 0; k < 12 * 4; k++)
            send_pixel(pixel_t'($urandom()), 1'b0, '0);

        hold_until_drained();
        if (mismatches == 0)
            $display("PASS gaussian_blur_3x3_rgb");
        else
            $display("FAIL gaussian_blur_3x3_rgb");
        $finish;
    end

endmodule

/* files.f */
rtl/gbr_pkg.sv
rtl/gbr_front.sv
rtl/gbr_fifo.sv
rtl/gbr_back.sv
rtl/gaussian_blur_3x3_rgb.sv
bench/tb_gaussian_blur_3x3_rgb.sv
